// File: src/trimmed_mean_phase_scaler_unit_assert.svh
// assertion macros for the trimmed-mean phase scaler
`ifndef TRIMMED_MEAN_PHASE_SCALER_UNIT_ASSERT_SVH
`define TRIMMED_MEAN_PHASE_SCALER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TMPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TMPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tmps_pkg.sv
// shared types, constants and helper functions of the trimmed-mean phase scaler
package tmps_pkg;

    localparam int BURST_LEN = 7;
    localparam int CHANNELS  = 7;
    localparam int NUM_IN    = 7;
    localparam int NUM_OUT   = 7;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 26;
    localparam int OUT_W     = 26;
    localparam int FRAC_W    = 16;
    localparam int OPND_W    = SAMPLE_W + 2;
    localparam int PROD_W    = OPND_W + GAIN_W;
    localparam int Q_W       = PROD_W - FRAC_W;

    localparam int IDX_W     = $clog2(BURST_LEN);
    localparam int PHASE_W   = $clog2(BURST_LEN);
    localparam int MID       = BURST_LEN / 2;
    localparam int CH_W      = $clog2(NUM_OUT);
    localparam int CFG_IDX_W = $clog2(NUM_OUT);

    localparam int IN_TDATA_W  = ((NUM_IN * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NUM_OUT * OUT_W + 7) / 8) * 8;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // channels that go through the line-to-phase conversion
    localparam logic [CH_W-1:0] CH_VA = CH_W'(0);
    localparam logic [CH_W-1:0] CH_VB = CH_W'(1);

    // floor division by three: bias to non-negative, multiply by reciprocal
    localparam int           DIV3_OFFS  = 2 ** (Q_W - 1);
    localparam logic [31:0]  DIV3_BIAS  = 32'(3 * DIV3_OFFS);
    localparam logic [31:0]  DIV3_MAGIC = 32'hAAAA_AAAB;
    localparam int           DIV3_SHIFT = 33;

    localparam logic signed [31:0] OUT_MAX = 32'sd33554431;
    localparam logic signed [31:0] OUT_MIN = -32'sd33554432;
    localparam logic signed [SAMPLE_W+1:0] SMP_MAX = (SAMPLE_W+2)'(32767);
    localparam logic signed [SAMPLE_W+1:0] SMP_MIN = -(SAMPLE_W+2)'(32768);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [CHANNELS-1:0]     t_row;
    typedef t_sample [NUM_OUT-1:0]      t_sums;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef t_gain [NUM_OUT-1:0]        t_gain_bank;
    typedef logic signed [OUT_W-1:0]    t_res;
    typedef t_res [NUM_OUT-1:0]         t_res_bank;

    localparam t_gain_bank GAIN_RESET = {
        26'd174326, 26'd38928384, 26'd1020396, 26'd734003,
        26'd65536, 26'd6742494, 26'd6791542
    };

    typedef enum logic [1:0] {
        F_ACCEPT,
        F_SORT,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_SAT,
        B_DONE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_sample sample_of(logic [IN_TDATA_W-1:0] d, int c);
        t_sample s;
        s = '0;
        if (c < NUM_IN) begin
            s = t_sample'(d >> (SAMPLE_W * c));
        end
        return s;
    endfunction

    function automatic t_res sat_out(logic signed [31:0] v);
        t_res r;
        if (v > OUT_MAX) begin
            r = t_res'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            r = t_res'(OUT_MIN);
        end else begin
            r = t_res'(v);
        end
        return r;
    endfunction

endpackage

// File: src/tmps_queue.sv
// two-entry queue of trimmed sums between the sort front end and the scaling back end
module tmps_queue import tmps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sums   i_data,
    input  logic    i_pop,
    output t_sums   o_data,
    output t_q_stat o_stat
);

    t_sums              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// File: src/tmps_front.sv
// front end: sample store, burst tracking and per-channel odd-even transposition sort
module tmps_front import tmps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    input  t_row    i_row,
    output logic    o_ready,
    output logic    o_push,
    output t_sums   o_sums,
    input  t_q_stat i_q_stat
);

    t_front_state       r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [PHASE_W-1:0] r_phase, n_phase;

    t_row    r_store [BURST_LEN];
    t_sample r_work  [CHANNELS][BURST_LEN];
    t_sample n_work  [CHANNELS][BURST_LEN];

    logic w_accept;

    function automatic t_sample trim_sum(t_sample a, t_sample b, t_sample c);
        logic signed [SAMPLE_W+1:0] s;
        t_sample r;
        s = (SAMPLE_W+2)'(a) + (SAMPLE_W+2)'(b) + (SAMPLE_W+2)'(c);
        if (s > SMP_MAX) begin
            r = t_sample'(SMP_MAX);
        end else if (s < SMP_MIN) begin
            r = t_sample'(SMP_MIN);
        end else begin
            r = t_sample'(s);
        end
        return r;
    endfunction

    assign w_accept = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_phase = r_phase;
        case (r_state)
            F_ACCEPT: begin
                if (i_valid) begin
                    if (i_last) begin
                        n_idx   = '0;
                        n_phase = '0;
                        n_state = F_SORT;
                    end else begin
                        n_idx = (r_idx == IDX_W'(BURST_LEN - 1)) ? '0 : r_idx + 1'b1;
                    end
                end
            end
            F_SORT: begin
                if (r_phase == PHASE_W'(BURST_LEN - 1)) begin
                    n_state = F_PUSH;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = F_ACCEPT;
                end
            end
            default: begin
                n_state = F_ACCEPT;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            F_ACCEPT: o_ready = 1'b1;
            F_PUSH:   o_push  = !i_q_stat.full;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    // burst snapshot at the burst end, then one compare-exchange layer per cycle
    always_comb begin
        n_work = r_work;
        if (w_accept && i_last) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < BURST_LEN; k++) begin
                    n_work[c][k] = (IDX_W'(k) == r_idx) ? i_row[c] : r_store[k][c];
                end
            end
        end else if (r_state == F_SORT) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int i = 0; i < BURST_LEN - 1; i++) begin
                    if ((1'(i) == r_phase[0]) && (r_work[c][i] > r_work[c][i+1])) begin
                        n_work[c][i]   = r_work[c][i+1];
                        n_work[c][i+1] = r_work[c][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_ACCEPT;
            r_idx   <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[r_idx] <= i_row;
        end
        r_work <= n_work;
    end

    for (genvar go = 0; go < NUM_OUT; go++) begin : g_sum
        if (go < CHANNELS) begin : g_live
            assign o_sums[go] = trim_sum(r_work[go][MID-1], r_work[go][MID],
                                         r_work[go][MID+1]);
        end else begin : g_none
            assign o_sums[go] = '0;
        end
    end

endmodule

// File: src/tmps_back.sv
// back end: line-to-phase conversion and gain scaling on one shared multiplier
module tmps_back import tmps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_gain_bank i_gains,
    input  t_sums      i_q_data,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res_bank  o_res
);

    t_back_state       r_state, n_state;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic              r_out_valid, n_out_valid;

    t_sums                     r_sums, n_sums;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [Q_W-1:0]     r_q, n_q;
    logic [63:0]               r_qp, n_qp;
    t_res_bank                 r_res, n_res;
    t_res_bank                 r_out, n_out;

    logic                     w_load;
    logic                     w_out_free;
    logic signed [OPND_W-1:0] w_s0, w_s1, w_opnd;
    logic [31:0]              w_u;
    logic signed [31:0]       w_div, w_full;

    assign w_out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_ch    = '0;
                    n_state = B_MUL;
                end
            end
            B_MUL: n_state = B_DIV;
            B_DIV: n_state = B_SAT;
            B_SAT: begin
                if (r_ch == CH_W'(NUM_OUT - 1)) begin
                    n_state = B_DONE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = B_MUL;
                end
            end
            B_DONE: begin
                if (w_out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            B_IDLE:  o_pop  = !i_q_stat.empty;
            B_DONE:  w_load = w_out_free;
            default: begin
                o_pop  = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        w_s0 = OPND_W'(r_sums[CH_VA]);
        w_s1 = OPND_W'(r_sums[CH_VB]);
        case (r_ch)
            CH_VA:   w_opnd = (w_s0 <<< 1) + w_s1;
            CH_VB:   w_opnd = w_s1 - w_s0;
            default: w_opnd = OPND_W'(r_sums[r_ch]);
        endcase

        n_sums = o_pop ? i_q_data : r_sums;
        n_prod = w_opnd * $signed({1'b0, i_gains[r_ch]});

        // floor shift of the q16 product, then biased reciprocal multiply for the /3
        n_q  = $signed(r_prod[PROD_W-1:FRAC_W]);
        w_u  = 32'(n_q) + DIV3_BIAS;
        n_qp = 64'(w_u) * 64'(DIV3_MAGIC);

        w_div  = $signed(32'(r_qp[63:DIV3_SHIFT])) - 32'(DIV3_OFFS);
        w_full = ((r_ch == CH_VA) || (r_ch == CH_VB)) ? w_div : 32'(r_q);

        n_res = r_res;
        if (r_state == B_SAT) begin
            n_res[r_ch] = sat_out(w_full);
        end

        n_out       = w_load ? r_res : r_out;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sums <= n_sums;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_qp   <= n_qp;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// File: src/trimmed_mean_phase_scaler_unit.sv
// trimmed_mean_phase_scaler_unit: seven-channel trimmed-mean filter with phase conversion
// a sample transfer that does not end a burst leaves the input open; a burst-end transfer
// blocks the input through 7 transposition-sort phases and 1 queue push, longer if full
// the back end steps each channel through its multiply, divide and saturate states on one
// shared gain multiplier and pops the next sums only after loading the output register
// synchronous active-low reset loads the gain reset values; the sample store is not cleared
`include "trimmed_mean_phase_scaler_unit_assert.svh"

module trimmed_mean_phase_scaler_unit import tmps_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_line_ab, sample_line_bc, sample_cur_a, sample_cur_b, sample_cur_c,
    // sample_dc_volt, sample_aux_cur (16 bits each, lowest first)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // phase_volt_a, phase_volt_b, current_a, current_b, current_c, dc_voltage,
    // aux_current (26 bits each, lowest first), 2 zero bits on top
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data
);

    t_gain_bank r_gains;
    t_row       w_row;
    logic       w_push;
    logic       w_pop;
    t_sums      w_push_data;
    t_sums      w_q_data;
    t_q_stat    w_q_stat;
    t_res_bank  w_res;
    logic       w_last_xfer;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= GAIN_RESET;
        end else if (i_cfg_valid && (32'(i_cfg_index) < 32'(NUM_OUT))) begin
            r_gains[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_row[c] = sample_of(s_axis_tdata, c);
        end
    end

    tmps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_last   (s_axis_tlast),
        .i_row    (w_row),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_sums   (w_push_data),
        .i_q_stat (w_q_stat)
    );

    tmps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    tmps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gains  (r_gains),
        .i_q_data (w_q_data),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (w_res)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_res);

    assign w_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    `TMPS_ASSERT_IMP(a_push_not_full, w_push, !w_q_stat.full, "push into a full queue")
    `TMPS_ASSERT_IMP(a_pop_not_empty, w_pop, !w_q_stat.empty, "pop from an empty queue")
    `TMPS_ASSERT_NXT(a_burst_end_busy, w_last_xfer, !s_axis_tready, "input open after burst end")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench of the trimmed-mean phase scaler: directed table, then random bursts
`timescale 1ns / 100ps

module testbench;
    import tmps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VB  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IA  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IB  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IC  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VDC = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ISC = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = CFG_IDX_W'(7);

    localparam t_gain  GAIN_MAX      = 26'h3FF_FFFF;
    localparam t_gain  GAIN_UNITY    = 26'd65536;
    localparam longint GAIN_ONE      = longint'(1) << FRAC_W;
    localparam longint PHASE_DIV     = 3 * GAIN_ONE;
    localparam int     NUM_PHASES    = 6;
    localparam int     PHASE_ITEMS   = 90;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     WATCHDOG_MAX  = 4000;

    localparam string FIELD_NAME [NUM_OUT] = '{
        "phase_volt_a", "phase_volt_b", "current_a", "current_b",
        "current_c", "dc_voltage", "aux_current"
    };

    typedef struct {
        t_row      smp;
        bit        last;
        bit        typed;
        t_res_bank exp;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [GAIN_W-1:0]      i_cfg_data = '0;

    // predictor state
    t_sample    pred_store [CHANNELS][BURST_LEN];
    int         pred_slot = 0;
    t_gain_bank pred_gain;

    t_res_bank  scaled_queue [$];
    t_dir_row   dir_rows [$];
    int         mismatch_count = 0;
    int         sender_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         stall_cycles = 0;

    trimmed_mean_phase_scaler_unit dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic t_res clamp26(longint v);
        t_res r;
        if (v > OUT_MAX) begin
            r = t_res'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            r = t_res'(OUT_MIN);
        end else begin
            r = t_res'(v);
        end
        return r;
    endfunction

    // sum of the three middle ranks of one channel, saturated to 16 bits
    function automatic int middle_sum(int ch);
        int vals [BURST_LEN];
        int key;
        int i;
        int j;
        int acc;
        for (i = 0; i < BURST_LEN; i++) begin
            vals[i] = pred_store[ch][i];
        end
        for (i = 1; i < BURST_LEN; i++) begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > key) begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = key;
        end
        acc = vals[MID - 1] + vals[MID] + vals[MID + 1];
        if (acc > 32767) begin
            acc = 32767;
        end else if (acc < -32768) begin
            acc = -32768;
        end
        return acc;
    endfunction

    task automatic filter_and_scale(input t_row smp, input bit last,
                                    output bit has_res, output t_res_bank res);
        longint s0;
        longint s1;
        int c;
        res = '0;
        has_res = 1'b0;
        for (c = 0; c < CHANNELS; c++) begin
            pred_store[c][pred_slot] = smp[c];
        end
        if (!last) begin
            pred_slot = (pred_slot == BURST_LEN - 1) ? 0 : pred_slot + 1;
        end else begin
            pred_slot = 0;
            has_res = 1'b1;
            s0 = middle_sum(0);
            s1 = middle_sum(1);
            res[REG_GAIN_VA] = clamp26(floor_quot((2 * s0 + s1) *
                longint'(pred_gain[REG_GAIN_VA]), PHASE_DIV));
            res[REG_GAIN_VB] = clamp26(floor_quot((s1 - s0) *
                longint'(pred_gain[REG_GAIN_VB]), PHASE_DIV));
            for (c = 2; c < NUM_OUT; c++) begin
                res[c] = clamp26(floor_quot(longint'(middle_sum(c)) *
                    longint'(pred_gain[c]), GAIN_ONE));
            end
        end
    endtask

    // one sample transfer, then at a burst end the predicted result goes to the queue
    task automatic transfer_sample(input t_row smp, input bit last,
                                   input bit typed, input t_res_bank typed_exp);
        bit        has_res;
        t_res_bank res;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(smp);
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        filter_and_scale(smp, last, has_res, res);
        if (has_res) begin
            scaled_queue.push_back(typed ? typed_exp : res);
        end
    endtask

    // leaves i_cfg_valid high; the caller lowers it after the last write
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input t_gain val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_OUT) begin
            pred_gain[idx] = val;
        end
    endtask

    task automatic set_gains(input t_gain_bank g);
        write_gain(REG_GAIN_VA, g[REG_GAIN_VA]);
        write_gain(REG_GAIN_VB, g[REG_GAIN_VB]);
        write_gain(REG_GAIN_IA, g[REG_GAIN_IA]);
        write_gain(REG_GAIN_IB, g[REG_GAIN_IB]);
        write_gain(REG_GAIN_IC, g[REG_GAIN_IC]);
        write_gain(REG_GAIN_VDC, g[REG_GAIN_VDC]);
        write_gain(REG_GAIN_ISC, g[REG_GAIN_ISC]);
        // no register behind this index, the write must change nothing
        write_gain(REG_SPARE, t_gain'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (scaled_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample v;
        case ($urandom_range(9))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = t_sample'(int'($urandom_range(200)) - 100);
            default: v = t_sample'($urandom);
        endcase
        return v;
    endfunction

    task automatic random_bursts(input int n_items);
        int   count;
        int   len;
        int   k;
        int   c;
        int   pick;
        t_row smp;
        count = 0;
        while (count < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = BURST_LEN;
            end else if (pick < 85) begin
                len = $urandom_range(BURST_LEN - 1, 1);
            end else begin
                len = $urandom_range(2 * BURST_LEN - 1, BURST_LEN + 1);
            end
            for (k = 0; k < len; k++) begin
                for (c = 0; c < CHANNELS; c++) begin
                    smp[c] = rand_sample();
                end
                transfer_sample(smp, k == len - 1, 1'b0, '0);
                count++;
            end
        end
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        t_res_bank want;
        t_res_bank got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res_bank'(m_axis_tdata[NUM_OUT*OUT_W-1:0]);
            if (scaled_queue.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, got %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = scaled_queue.pop_front();
                for (int c = 0; c < NUM_OUT; c++) begin
                    if (got[c] !== want[c]) begin
                        $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                 FIELD_NAME[c], $signed(want[c]), $signed(got[c]));
                        mismatch_count++;
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (stall_cycles < WATCHDOG_MAX) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_dir_row   row;
        t_gain_bank g;
        int         snd_pct [NUM_PHASES];
        int         rcv_pct [NUM_PHASES];
        int         k;
        int         c;
        int         ph;

        snd_pct = '{17, 17, 56, 56, 0, 0};
        rcv_pct = '{56, 56, 17, 17, 0, 0};
        pred_gain[REG_GAIN_VA]  = 26'd6791542;
        pred_gain[REG_GAIN_VB]  = 26'd6742494;
        pred_gain[REG_GAIN_IA]  = 26'd65536;
        pred_gain[REG_GAIN_IB]  = 26'd734003;
        pred_gain[REG_GAIN_IC]  = 26'd1020396;
        pred_gain[REG_GAIN_VDC] = 26'd38928384;
        pred_gain[REG_GAIN_ISC] = 26'd174326;

        // all-zero burst fills every slot after reset, result is zero on every field
        for (k = 0; k < BURST_LEN; k++) begin
            row.smp = '0;
            row.last = (k == BURST_LEN - 1);
            row.typed = row.last;
            row.exp = '0;
            dir_rows.push_back(row);
        end
        // full-scale positive burst, middle sum saturates high
        for (k = 0; k < BURST_LEN; k++) begin
            row.smp = {CHANNELS{16'sh7FFF}};
            row.last = (k == BURST_LEN - 1);
            row.typed = 1'b0;
            dir_rows.push_back(row);
        end
        // short burst, older samples still join the sort
        for (k = 0; k < 2; k++) begin
            row.smp = {CHANNELS{16'sh8000}};
            row.last = (k == 1);
            row.typed = 1'b0;
            dir_rows.push_back(row);
        end
        // long burst wraps the slot index, saturates low, distinct channel values at the end
        for (k = 0; k < BURST_LEN + 2; k++) begin
            for (c = 0; c < CHANNELS; c++) begin
                row.smp[c] = (k < BURST_LEN) ? 16'sh8000 : t_sample'(c * 4100 - 12000 + k);
            end
            row.last = (k == BURST_LEN + 1);
            row.typed = 1'b0;
            dir_rows.push_back(row);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = snd_pct[0];
        recv_idle_pct   = rcv_pct[0];
        foreach (dir_rows[i]) begin
            transfer_sample(dir_rows[i].smp, dir_rows[i].last, dir_rows[i].typed,
                            dir_rows[i].exp);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                1: g = {NUM_OUT{GAIN_MAX}};
                2: g = '0;
                4: g = {NUM_OUT{GAIN_UNITY}};
                default: begin
                    for (c = 0; c < NUM_OUT; c++) begin
                        g[c] = t_gain'($urandom_range(GAIN_MAX) >> $urandom_range(20));
                    end
                end
            endcase
            set_gains(g);
            sender_idle_pct = snd_pct[ph];
            recv_idle_pct   = rcv_pct[ph];
            random_bursts(PHASE_ITEMS);
        end
        drain_results();

        if (mismatch_count == 0 && scaled_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
